[rtl/sfcp_pkg.sv]
// Shared types and constants of the SPI flash command planner.
package sfcp_pkg;

	localparam int ADDR_W = 24;
	localparam int LEN_W  = 25;

	localparam int PAGE_BYTES    = 256;
	localparam int SECTOR_BYTES  = 4096;
	localparam int ADDRESS_BITS  = 24;
	localparam int BLOCK32_BYTES = 256 * 128;
	localparam int BLOCK64_BYTES = 256 * 256;

	localparam int PAGE_SH    = $clog2(PAGE_BYTES);
	localparam int SECTOR_SH  = $clog2(SECTOR_BYTES);
	localparam int BLOCK32_SH = $clog2(BLOCK32_BYTES);
	localparam int BLOCK64_SH = $clog2(BLOCK64_BYTES);

	localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);
	localparam logic [LEN_W-1:0]  CAPACITY_RESET = LEN_W'(8388608);

	localparam logic [7:0] OP_NONE          = 8'h00;
	localparam logic [7:0] OP_READ          = 8'h03;
	localparam logic [7:0] OP_PROGRAM       = 8'h02;
	localparam logic [7:0] OP_SECTOR_ERASE  = 8'h20;
	localparam logic [7:0] OP_BLOCK32_ERASE = 8'h52;
	localparam logic [7:0] OP_BLOCK64_ERASE = 8'hD8;
	localparam logic [7:0] OP_CHIP_ERASE    = 8'h60;

	typedef enum logic [1:0] {
		CMD_READ    = 2'd0,
		CMD_PROGRAM = 2'd1,
		CMD_ERASE   = 2'd2,
		CMD_POLL    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ISSUED = 3'd0,
		ST_DONE   = 3'd1,
		ST_RANGE  = 3'd2,
		ST_ALIGN  = 3'd3,
		ST_PAGE   = 3'd4,
		ST_BUSY   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]        opcode;
		logic [ADDR_W-1:0] next_addr;
		logic [LEN_W-1:0]  next_rem;
	} erase_step_t;

	typedef struct packed {
		logic [7:0]        opcode;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  bytes;
		logic              wel;
		status_t           status;
	} result_t;

endpackage

[rtl/sfcp_erase_step.sv]
// Picks the largest aligned erase block that fits and advances the erase cursor.
module sfcp_erase_step import sfcp_pkg::*; (
	input  logic [ADDR_W-1:0] base,
	input  logic [LEN_W-1:0]  remaining,
	output erase_step_t       step
);

	logic [LEN_W-1:0] size;

	always_comb begin
		if (base[BLOCK64_SH-1:0] == '0 && remaining >= LEN_W'(BLOCK64_BYTES)) begin
			size        = LEN_W'(BLOCK64_BYTES);
			step.opcode = OP_BLOCK64_ERASE;
		end else if (base[BLOCK32_SH-1:0] == '0 && remaining >= LEN_W'(BLOCK32_BYTES)) begin
			size        = LEN_W'(BLOCK32_BYTES);
			step.opcode = OP_BLOCK32_ERASE;
		end else begin
			size        = LEN_W'(SECTOR_BYTES);
			step.opcode = OP_SECTOR_ERASE;
		end
		step.next_rem  = (remaining >= size) ? remaining - size : '0;
		step.next_addr = base + size[ADDR_W-1:0];
	end

endmodule

[rtl/spi_flash_command_planner_unit.sv]
// Top level of the SPI flash command planner: request decode, erase sequencer and result register.
//
// Requests (read, page program, erase range) and status poll results enter on the
// in_valid/in_ready channel; one planned flash command or status report leaves on the
// out_valid/out_ready channel for each item that produces one. A status poll with the
// device busy, or with no erase pending, produces nothing.
// An accepted item is held in an input register, decoded there against the erase state,
// and its result is loaded into the output register, from which the receiver takes it.
// One item per cycle is sustained while the receiver takes each result; the only
// sequential dependence is the erase state, which the decode stage updates in the same
// cycle it loads the output register. When the receiver stalls, the output register
// holds its result and the input register holds the next item; in_ready drops only
// when both are full. Reset empties both registers, clears the pending erase and sets
// the capacity register to 8 MB. The capacity register is written with cfg_we/cfg_wdata;
// the user must do so only while idle, which the block itself does not enforce.
module spi_flash_command_planner_unit import sfcp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  logic [ADDR_W-1:0] start_address,
	input  logic [LEN_W-1:0]  byte_length,
	input  logic              device_busy,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        opcode,
	output logic [ADDR_W-1:0] flash_address,
	output logic [LEN_W-1:0]  transfer_bytes,
	output logic              write_enable_first,
	output logic [2:0]        status
);

	logic [LEN_W-1:0]  capacity_q;
	logic              erase_pending_q;
	logic [ADDR_W-1:0] next_addr_q;
	logic [LEN_W-1:0]  remaining_q;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              busy_s1;

	logic              out_valid_q;
	result_t           result_s2;

	logic              advance_s1;
	logic              res_valid;
	result_t           res;
	logic              pending_d;
	logic [ADDR_W-1:0] next_addr_d;
	logic [LEN_W-1:0]  remaining_d;

	logic [ADDR_W-1:0] step_base;
	logic [LEN_W-1:0]  step_rem;
	erase_step_t       step;

	logic [LEN_W:0]    addr_ext;
	logic [LEN_W:0]    end_sum;
	logic [LEN_W:0]    page_last;
	logic              page_bad;
	logic              out_of_range;
	logic              misaligned;

	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	// A poll continues the pending erase; an erase request starts a new one.
	assign step_base = (cmd_s1 == CMD_POLL) ? next_addr_q : addr_s1;
	assign step_rem  = (cmd_s1 == CMD_POLL) ? remaining_q : len_s1;

	sfcp_erase_step u_step (
		.base      (step_base),
		.remaining (step_rem),
		.step      (step)
	);

	assign addr_ext     = {2'b00, addr_s1};
	assign end_sum      = addr_ext + {1'b0, len_s1};
	assign page_last    = end_sum - (LEN_W+1)'(1);
	assign page_bad     = (len_s1 == '0) || (len_s1 > LEN_W'(PAGE_BYTES))
		|| (page_last[LEN_W:PAGE_SH] != addr_ext[LEN_W:PAGE_SH]);
	assign out_of_range = end_sum > {1'b0, capacity_q};
	assign misaligned   = (addr_s1[SECTOR_SH-1:0] != '0) || (len_s1[SECTOR_SH-1:0] != '0);

	always_comb begin
		res_valid   = 1'b0;
		res         = '0;
		res.status  = ST_ISSUED;
		pending_d   = erase_pending_q;
		next_addr_d = next_addr_q;
		remaining_d = remaining_q;
		if (cmd_s1 == CMD_POLL) begin
			if (erase_pending_q && !busy_s1) begin
				res_valid = 1'b1;
				if (remaining_q == '0) begin
					pending_d  = 1'b0;
					res.status = ST_DONE;
				end else begin
					res.opcode  = step.opcode;
					res.address = next_addr_q & ADDR_MASK;
					res.wel     = 1'b1;
					next_addr_d = step.next_addr;
					remaining_d = step.next_rem;
				end
			end
		end else if (erase_pending_q) begin
			res_valid  = 1'b1;
			res.status = ST_BUSY;
		end else begin
			res_valid = 1'b1;
			case (cmd_s1)
				CMD_READ: begin
					res.opcode  = OP_READ;
					res.address = addr_s1 & ADDR_MASK;
					res.bytes   = len_s1;
				end
				CMD_PROGRAM: begin
					if (page_bad) begin
						res.status = ST_PAGE;
					end else begin
						res.opcode  = OP_PROGRAM;
						res.address = addr_s1 & ADDR_MASK;
						res.bytes   = len_s1;
						res.wel     = 1'b1;
					end
				end
				default: begin
					if (out_of_range) begin
						res.status = ST_RANGE;
					end else if (misaligned) begin
						res.status = ST_ALIGN;
					end else if (len_s1 == '0) begin
						res.status = ST_DONE;
					end else if (addr_s1 == '0 && len_s1 == capacity_q) begin
						res.opcode  = OP_CHIP_ERASE;
						res.wel     = 1'b1;
						pending_d   = 1'b1;
						next_addr_d = '0;
						remaining_d = '0;
					end else begin
						res.opcode  = step.opcode;
						res.address = addr_s1 & ADDR_MASK;
						res.wel     = 1'b1;
						pending_d   = 1'b1;
						next_addr_d = step.next_addr;
						remaining_d = step.next_rem;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q      <= CAPACITY_RESET;
			erase_pending_q <= 1'b0;
			next_addr_q     <= '0;
			remaining_q     <= '0;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance_s1) begin
				erase_pending_q <= pending_d;
				next_addr_q     <= next_addr_d;
				remaining_q     <= remaining_d;
				out_valid_q     <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd_t'(command);
			addr_s1 <= start_address;
			len_s1  <= byte_length;
			busy_s1 <= device_busy;
		end
		if (advance_s1 && res_valid) begin
			result_s2 <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign opcode             = result_s2.opcode;
	assign flash_address      = result_s2.address;
	assign transfer_bytes     = result_s2.bytes;
	assign write_enable_first = result_s2.wel;
	assign status             = result_s2.status;

	// With no erase pending there must be nothing left to erase.
	a_idle_no_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		!erase_pending_q |-> remaining_q == '0)
		else $error("erase bytes remain with no erase pending");

	// The erase cursor moves in whole sectors only.
	a_sector_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		next_addr_q[SECTOR_SH-1:0] == '0 && remaining_q[SECTOR_SH-1:0] == '0)
		else $error("erase cursor left sector alignment");

	// A report other than a command issue carries no opcode.
	a_report_no_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ISSUED |-> opcode == OP_NONE && write_enable_first == 1'b0)
		else $error("status report carries a command");

endmodule
